// ===== hdl/vram_block_dma_controller_macros.svh =====
// Assertion macros used by the video-memory block DMA controller top level.
`ifndef VRAM_BLOCK_DMA_CONTROLLER_MACROS_SVH
`define VRAM_BLOCK_DMA_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define VBDMA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vbdma same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define VBDMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vbdma next-cycle check failed");

`endif

// ===== hdl/vbdma_pkg.sv =====
// Types, codes and constants of the video-memory block DMA controller.
package vbdma_pkg;

  typedef enum logic [1:0] {
    OP_ADDR_WRITE = 2'd0,
    OP_CTRL_WRITE = 2'd1,
    OP_REG_READ   = 2'd2,
    OP_LINE_EVENT = 2'd3
  } opcode_t;

  // Register numbers on the address write and readback paths.
  localparam logic [2:0] REG_SRC_HI    = 3'd1;
  localparam logic [2:0] REG_SRC_LO    = 3'd2;
  localparam logic [2:0] REG_DEST_HI   = 3'd3;
  localparam logic [2:0] REG_DEST_LO   = 3'd4;
  localparam logic [2:0] REG_READ_LAST = 3'd5;

  localparam logic [15:0] DEST_RESET     = 16'h8000;
  localparam logic [15:0] SRC_LINE_GAP   = 16'h8000;
  localparam logic [15:0] SRC_LINE_JUMP  = 16'hA000;
  localparam logic [15:0] DEST_LINE_END  = 16'hA000;
  localparam logic [15:0] BLOCK_STEP     = 16'h0010;
  localparam logic [7:0]  SRC_HI_BAD_LO  = 8'h80;
  localparam logic [7:0]  SRC_HI_BAD_HI  = 8'h9F;
  localparam logic [7:0]  BYTE_ALL_ONES  = 8'hFF;
  localparam logic [11:0] LINE_LENGTH    = 12'h010;
  localparam logic [13:0] LINE_STALL_DS  = 14'd68;
  localparam logic [13:0] LINE_STALL_SS  = 14'd36;
  localparam logic [13:0] GEN_STALL_DS   = 14'd8;
  localparam logic [13:0] GEN_STALL_SS   = 14'd4;

  typedef struct packed {
    opcode_t    opcode;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic       in_hblank;
    logic       double_speed;
  } item_t;

  typedef struct packed {
    logic        copy_valid;
    logic [15:0] copy_source;
    logic [15:0] copy_dest;
    logic [11:0] copy_length;
    logic [13:0] stall_cycles;
    logic [7:0]  read_data;
  } result_t;

  typedef struct packed {
    logic [15:0]     source_address;
    logic [15:0]     dest_address;
    logic            line_mode_enabled;
    logic [4:0][7:0] readback_bytes;
  } state_t;

endpackage

// ===== hdl/vbdma_core.sv =====
// Next-state and result logic for one controller item.
module vbdma_core
  import vbdma_pkg::*;
(
  input  state_t  st,
  input  item_t   item,
  output state_t  st_next,
  output result_t res
);

  logic [15:0] src_step;
  logic [15:0] dest_step;
  logic [7:0]  n_plus;
  logic [11:0] gen_len;
  logic [13:0] gen_stall;
  logic [7:0]  count_base;
  logic [7:0]  count_dec;
  logic [2:0]  rd_idx;
  logic        do_line;
  logic [7:0]  src_hi;

  // Address advance for one line block, with the wrap and jump rules.
  always_comb begin
    src_step  = st.source_address + BLOCK_STEP;
    dest_step = st.dest_address + BLOCK_STEP;
    if (src_step == SRC_LINE_GAP) begin
      src_step = SRC_LINE_JUMP;
    end
    if (dest_step == DEST_LINE_END) begin
      dest_step = DEST_RESET;
    end
  end

  // General copy length and stall from the block count in the control byte.
  assign n_plus    = {1'b0, item.write_data[6:0]} + 8'd1;
  assign gen_len   = {n_plus, 4'b0000};
  assign gen_stall = item.double_speed ? ({n_plus, 6'b000000} + GEN_STALL_DS)
                                       : ({1'b0, n_plus, 5'b00000} + GEN_STALL_SS);
  assign rd_idx    = item.reg_index - 3'd1;
  assign src_hi    = ((item.write_data >= SRC_HI_BAD_LO) && (item.write_data <= SRC_HI_BAD_HI))
                     ? 8'h00 : item.write_data;

  // Operation decode and state update.
  always_comb begin
    st_next    = st;
    res        = '0;
    do_line    = 1'b0;
    count_base = st.readback_bytes[4];
    unique case (item.opcode)
      OP_ADDR_WRITE: begin
        unique case (item.reg_index)
          REG_SRC_HI: begin
            st_next.source_address = {src_hi, st.source_address[7:4], 4'h0};
          end
          REG_SRC_LO: begin
            st_next.source_address = {st.source_address[15:8], item.write_data[7:4], 4'h0};
          end
          REG_DEST_HI: begin
            st_next.dest_address = {3'b100, item.write_data[4:0], st.dest_address[7:4], 4'h0};
          end
          REG_DEST_LO: begin
            st_next.dest_address = {3'b100, st.dest_address[12:8], item.write_data[7:4], 4'h0};
          end
          default: begin
          end
        endcase
      end
      OP_CTRL_WRITE: begin
        if (st.line_mode_enabled) begin
          if (item.write_data[7]) begin
            st_next.readback_bytes[4] = {1'b0, item.write_data[6:0]};
          end else begin
            st_next.readback_bytes[4] = BYTE_ALL_ONES;
            st_next.line_mode_enabled = 1'b0;
          end
        end else if (item.write_data[7]) begin
          st_next.line_mode_enabled = 1'b1;
          st_next.readback_bytes[4] = {1'b0, item.write_data[6:0]};
          count_base                = {1'b0, item.write_data[6:0]};
          do_line                   = item.in_hblank;
        end else begin
          res.copy_valid         = 1'b1;
          res.copy_source        = {st.source_address[15:4], 4'h0};
          res.copy_dest          = {3'b100, st.dest_address[12:4], 4'h0};
          res.copy_length        = gen_len;
          res.stall_cycles       = gen_stall;
          st_next.source_address = st.source_address + {4'h0, gen_len};
          st_next.dest_address   = st.dest_address + {4'h0, gen_len};
          st_next.readback_bytes = {5{BYTE_ALL_ONES}};
        end
      end
      OP_REG_READ: begin
        if ((item.reg_index != 3'd0) && (item.reg_index <= REG_READ_LAST)) begin
          res.read_data = st.readback_bytes[rd_idx];
        end else begin
          res.read_data = BYTE_ALL_ONES;
        end
      end
      OP_LINE_EVENT: begin
        do_line = st.line_mode_enabled;
      end
      default: begin
      end
    endcase

    // Block count after one line block.
    count_dec = count_base - 8'd1;

    // One 16-byte line block, shared by the arm path and the line event.
    if (do_line) begin
      res.copy_valid            = 1'b1;
      res.copy_source           = {st.source_address[15:4], 4'h0};
      res.copy_dest             = {3'b100, st.dest_address[12:4], 4'h0};
      res.copy_length           = LINE_LENGTH;
      res.stall_cycles          = item.double_speed ? LINE_STALL_DS : LINE_STALL_SS;
      st_next.source_address    = src_step;
      st_next.dest_address      = dest_step;
      st_next.readback_bytes[0] = src_step[15:8];
      st_next.readback_bytes[1] = src_step[7:0];
      st_next.readback_bytes[2] = dest_step[15:8];
      st_next.readback_bytes[3] = dest_step[7:0];
      st_next.readback_bytes[4] = count_dec;
      if (count_dec == BYTE_ALL_ONES) begin
        st_next.line_mode_enabled = 1'b0;
      end
    end
  end

endmodule

// ===== hdl/vram_block_dma_controller.sv =====
// Top level of the video-memory block DMA controller.
//
// Items come in on the input channel (in_valid / in_stall): address register
// writes, control writes, register reads and blanking line events. Every item
// gives exactly one result on the output channel (out_valid / out_stall):
// a copy request (copy_valid, source, destination, length, stall cycles) and
// a readback byte for register reads.
// An accepted item lands in the input register; when the result register is
// free, the core logic updates the controller state and loads the result
// register, which raises out_valid. The block takes one item every cycle
// while the receiver does not stall; the combinational core update sets that rate.
// Reset clears both pipeline registers and puts the state at its reset
// values: source 0, destination 0x8000, line mode off, readback bytes 0xFF.
// While the receiver stalls, the result register holds its item; the input
// register still fills once, and in_stall rises when it is full and the
// result cannot move on.
module vram_block_dma_controller
  import vbdma_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [2:0]  reg_index,
  input  logic [7:0]  write_data,
  input  logic        in_hblank,
  input  logic        double_speed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        copy_valid,
  output logic [15:0] copy_source,
  output logic [15:0] copy_dest,
  output logic [11:0] copy_length,
  output logic [13:0] stall_cycles,
  output logic [7:0]  read_data
);

`include "vram_block_dma_controller_macros.svh"

  logic    s1_valid;
  item_t   s1_item;
  logic    out_block;
  logic    s1_fire;
  state_t  st;
  state_t  st_next;
  result_t res;
  result_t out_res;

  assign out_block = out_valid && out_stall;
  assign s1_fire   = s1_valid && !out_block;
  assign in_stall  = s1_valid && out_block;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= '{opcode: opcode_t'(opcode), reg_index: reg_index,
                   write_data: write_data, in_hblank: in_hblank,
                   double_speed: double_speed};
    end
  end

  vbdma_core u_core (
    .st      (st),
    .item    (s1_item),
    .st_next (st_next),
    .res     (res)
  );

  // Controller state, updated when an item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.source_address    <= 16'h0000;
      st.dest_address      <= DEST_RESET;
      st.line_mode_enabled <= 1'b0;
      st.readback_bytes    <= {5{BYTE_ALL_ONES}};
    end else if (s1_fire) begin
      st <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_block) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res <= res;
    end
  end

  assign copy_valid   = out_res.copy_valid;
  assign copy_source  = out_res.copy_source;
  assign copy_dest    = out_res.copy_dest;
  assign copy_length  = out_res.copy_length;
  assign stall_cycles = out_res.stall_cycles;
  assign read_data    = out_res.read_data;

  // Internal consistency checks.
  `VBDMA_ASSERT_NOW(a_idle_result_clear, out_valid && !copy_valid, copy_length == 12'd0 && stall_cycles == 14'd0)
  `VBDMA_ASSERT_NOW(a_copy_dest_in_vram, out_valid && copy_valid, copy_dest[15:13] == 3'b100)
  `VBDMA_ASSERT_NOW(a_copy_len_blocks, out_valid && copy_valid, copy_length[3:0] == 4'h0 && copy_length != 12'd0)
  `VBDMA_ASSERT_NOW(a_stall_needs_full, in_stall, s1_valid && out_valid)
  `VBDMA_ASSERT_NEXT(a_fire_fills_out, s1_fire, out_valid)

endmodule

// ===== tb/vram_block_dma_controller_tb.sv =====
// Self-checking testbench for the video-memory block DMA controller.
`timescale 1ns / 1ps

module vram_block_dma_controller_tb
  import vbdma_pkg::*;
();

  // One queued bus item with its lead-in idle time.
  typedef struct {
    item_t       item;
    int unsigned gap;
    bit          drain_first;
  } bus_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = 2'd0;
  logic [2:0]  reg_index = 3'd0;
  logic [7:0]  write_data = 8'd0;
  logic        in_hblank = 1'b0;
  logic        double_speed = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        copy_valid;
  logic [15:0] copy_source;
  logic [15:0] copy_dest;
  logic [11:0] copy_length;
  logic [13:0] stall_cycles;
  logic [7:0]  read_data;

  bus_item_t   bus_items[$];
  result_t     copy_results_due[$];
  state_t      dma;
  int unsigned bus_items_total = 0;
  int unsigned bus_items_taken = 0;
  int unsigned error_count = 0;
  int unsigned send_calm = 0;
  int unsigned recv_calm = 0;
  bit          drain_next = 1'b0;

  vram_block_dma_controller DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .in_hblank    (in_hblank),
    .double_speed (double_speed),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .copy_valid   (copy_valid),
    .copy_source  (copy_source),
    .copy_dest    (copy_dest),
    .copy_length  (copy_length),
    .stall_cycles (stall_cycles),
    .read_data    (read_data)
  );

  always #6 clk = ~clk;

  // Idle time for one item: mostly random, with quiet stretches of none.
  function automatic int unsigned idle_draw(inout int unsigned calm_left);
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // One 16-byte line block; advances both addresses and the block count.
  function automatic result_t line_block(logic fast);
    result_t r;
    r = '0;
    r.copy_valid = 1'b1;
    r.copy_source = {dma.source_address[15:4], 4'h0};
    r.copy_dest = {3'b100, dma.dest_address[12:4], 4'h0};
    r.copy_length = LINE_LENGTH;
    r.stall_cycles = fast ? LINE_STALL_DS : LINE_STALL_SS;
    dma.dest_address = dma.dest_address + BLOCK_STEP;
    if (dma.dest_address == DEST_LINE_END) dma.dest_address = DEST_RESET;
    dma.source_address = dma.source_address + BLOCK_STEP;
    if (dma.source_address == SRC_LINE_GAP) dma.source_address = SRC_LINE_JUMP;
    dma.readback_bytes[0] = dma.source_address[15:8];
    dma.readback_bytes[1] = dma.source_address[7:0];
    dma.readback_bytes[2] = dma.dest_address[15:8];
    dma.readback_bytes[3] = dma.dest_address[7:0];
    dma.readback_bytes[4] = dma.readback_bytes[4] - 8'd1;
    if (dma.readback_bytes[4] == BYTE_ALL_ONES) dma.line_mode_enabled = 1'b0;
    return r;
  endfunction

  // Applies one accepted item to the controller state and returns its result.
  function automatic result_t dma_apply_item(item_t it);
    result_t     r;
    int unsigned blocks;
    logic [7:0]  v;
    r = '0;
    v = it.write_data;
    case (it.opcode)
      OP_ADDR_WRITE: begin
        case (it.reg_index)
          REG_SRC_HI: begin
            // The video-memory range is not a legal source page.
            if (v >= SRC_HI_BAD_LO && v <= SRC_HI_BAD_HI) v = 8'h00;
            dma.source_address = {v, dma.source_address[7:4], 4'h0};
          end
          REG_SRC_LO: dma.source_address = {dma.source_address[15:8], v[7:4], 4'h0};
          REG_DEST_HI: dma.dest_address = {3'b100, v[4:0], dma.dest_address[7:4], 4'h0};
          REG_DEST_LO: dma.dest_address = {3'b100, dma.dest_address[12:8], v[7:4], 4'h0};
          default: ;
        endcase
      end
      OP_CTRL_WRITE: begin
        if (dma.line_mode_enabled) begin
          // Re-arm keeps running; bit 7 clear stops the line mode.
          if (v[7]) begin
            dma.readback_bytes[4] = {1'b0, v[6:0]};
          end else begin
            dma.readback_bytes[4] = BYTE_ALL_ONES;
            dma.line_mode_enabled = 1'b0;
          end
        end else if (v[7]) begin
          dma.line_mode_enabled = 1'b1;
          dma.readback_bytes[4] = {1'b0, v[6:0]};
          if (it.in_hblank) r = line_block(it.double_speed);
        end else begin
          // General copy of all blocks at once, addresses unmasked afterwards.
          blocks = v[6:0] + 1;
          r.copy_valid = 1'b1;
          r.copy_source = {dma.source_address[15:4], 4'h0};
          r.copy_dest = {3'b100, dma.dest_address[12:4], 4'h0};
          r.copy_length = 12'(16 * blocks);
          r.stall_cycles = it.double_speed ? 14'(4 * (2 + 16 * blocks))
                                           : 14'(4 * (1 + 8 * blocks));
          dma.dest_address = dma.dest_address + 16'(16 * blocks);
          dma.source_address = dma.source_address + 16'(16 * blocks);
          dma.readback_bytes = {5{BYTE_ALL_ONES}};
        end
      end
      OP_REG_READ: begin
        if (it.reg_index >= REG_SRC_HI && it.reg_index <= REG_READ_LAST)
          r.read_data = dma.readback_bytes[it.reg_index - REG_SRC_HI];
        else
          r.read_data = BYTE_ALL_ONES;
      end
      default: begin
        if (dma.line_mode_enabled) r = line_block(it.double_speed);
      end
    endcase
    return r;
  endfunction

  task automatic queue_item(opcode_t op, logic [2:0] idx, logic [7:0] data,
                            logic hb, logic ds);
    bus_item_t b;
    b.item.opcode = op;
    b.item.reg_index = idx;
    b.item.write_data = data;
    b.item.in_hblank = hb;
    b.item.double_speed = ds;
    b.gap = idle_draw(send_calm);
    b.drain_first = drain_next;
    drain_next = 1'b0;
    bus_items.push_back(b);
  endtask

  // Sender: presents queued items, holds them while stalled, predicts on accept.
  bus_item_t   cur_item;
  bit          item_held = 1'b0;
  bit          item_shown = 1'b0;
  int unsigned send_wait = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        copy_results_due.push_back(dma_apply_item(cur_item.item));
        bus_items_taken++;
        item_held = 1'b0;
        item_shown = 1'b0;
      end
      if (!item_held && bus_items.size() != 0) begin
        cur_item = bus_items.pop_front();
        item_held = 1'b1;
        send_wait = cur_item.gap;
      end
      if (item_held && !item_shown) begin
        if (send_wait != 0) begin
          send_wait--;
        end else if (!cur_item.drain_first || copy_results_due.size() == 0) begin
          item_shown = 1'b1;
          opcode <= cur_item.item.opcode;
          reg_index <= cur_item.item.reg_index;
          write_data <= cur_item.item.write_data;
          in_hblank <= cur_item.item.in_hblank;
          double_speed <= cur_item.item.double_speed;
        end
      end
      in_valid <= item_shown;
    end
  end

  task automatic report_field(string name, logic [15:0] want, logic [15:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    error_count++;
  endtask

  // Receiver: random stalls, and each accepted result checked against the oldest due.
  int unsigned recv_wait = 0;

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (copy_results_due.size() == 0) begin
          $display("%0t: unexpected result, actual copy_valid %0b read_data 0x%0h",
                   $time, copy_valid, read_data);
          error_count++;
        end else begin
          want = copy_results_due.pop_front();
          if (copy_valid !== want.copy_valid)
            report_field("copy_valid", 16'(want.copy_valid), 16'(copy_valid));
          if (copy_source !== want.copy_source)
            report_field("copy_source", want.copy_source, copy_source);
          if (copy_dest !== want.copy_dest)
            report_field("copy_dest", want.copy_dest, copy_dest);
          if (copy_length !== want.copy_length)
            report_field("copy_length", 16'(want.copy_length), 16'(copy_length));
          if (stall_cycles !== want.stall_cycles)
            report_field("stall_cycles", 16'(want.stall_cycles), 16'(stall_cycles));
          if (read_data !== want.read_data)
            report_field("read_data", 16'(want.read_data), 16'(read_data));
        end
        recv_wait = idle_draw(recv_calm);
      end
      if (recv_wait != 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned k;
    int unsigned n;
    int unsigned events;
    int unsigned settle;

    dma.source_address = 16'h0000;
    dma.dest_address = DEST_RESET;
    dma.line_mode_enabled = 1'b0;
    dma.readback_bytes = {5{BYTE_ALL_ONES}};

    // Directed: reset readback, ignored registers, address edges, copy extremes.
    queue_item(OP_REG_READ, REG_READ_LAST, 8'h00, 1'b0, 1'b0);
    queue_item(OP_REG_READ, 3'd0, 8'hFF, 1'b1, 1'b1);
    queue_item(OP_REG_READ, 3'd7, 8'h00, 1'b0, 1'b0);
    queue_item(OP_LINE_EVENT, 3'd0, 8'h00, 1'b1, 1'b1);
    queue_item(OP_ADDR_WRITE, 3'd0, 8'hFF, 1'b0, 1'b0);
    queue_item(OP_ADDR_WRITE, 3'd5, 8'hFF, 1'b0, 1'b0);
    queue_item(OP_ADDR_WRITE, 3'd7, 8'hFF, 1'b0, 1'b0);
    queue_item(OP_ADDR_WRITE, REG_SRC_HI, 8'h85, 1'b0, 1'b0);
    queue_item(OP_CTRL_WRITE, 3'd0, 8'h00, 1'b0, 1'b0);
    queue_item(OP_ADDR_WRITE, REG_SRC_HI, 8'hFF, 1'b0, 1'b0);
    queue_item(OP_ADDR_WRITE, REG_SRC_LO, 8'hFF, 1'b0, 1'b0);
    queue_item(OP_ADDR_WRITE, REG_DEST_HI, 8'hFF, 1'b0, 1'b0);
    queue_item(OP_ADDR_WRITE, REG_DEST_LO, 8'hFF, 1'b0, 1'b0);
    queue_item(OP_CTRL_WRITE, 3'd7, 8'h7F, 1'b1, 1'b1);
    queue_item(OP_ADDR_WRITE, REG_SRC_HI, 8'h7F, 1'b0, 1'b0);
    queue_item(OP_ADDR_WRITE, REG_SRC_LO, 8'hF0, 1'b0, 1'b0);
    queue_item(OP_ADDR_WRITE, REG_DEST_HI, 8'h1F, 1'b0, 1'b0);
    queue_item(OP_ADDR_WRITE, REG_DEST_LO, 8'hF0, 1'b0, 1'b0);
    queue_item(OP_CTRL_WRITE, 3'd0, 8'h81, 1'b1, 1'b1);
    queue_item(OP_CTRL_WRITE, 3'd0, 8'h85, 1'b1, 1'b0);
    queue_item(OP_LINE_EVENT, 3'd0, 8'h00, 1'b0, 1'b0);
    queue_item(OP_REG_READ, REG_SRC_HI, 8'h00, 1'b0, 1'b0);
    queue_item(OP_REG_READ, REG_DEST_LO, 8'h00, 1'b0, 1'b0);
    queue_item(OP_CTRL_WRITE, 3'd0, 8'h00, 1'b0, 1'b0);
    queue_item(OP_CTRL_WRITE, 3'd0, 8'h80, 1'b0, 1'b1);
    queue_item(OP_LINE_EVENT, 3'd0, 8'h00, 1'b0, 1'b1);
    queue_item(OP_LINE_EVENT, 3'd0, 8'h00, 1'b0, 1'b0);

    // Random: mostly well-formed line runs and general copies, some noise.
    drain_next = 1'b1;
    while (bus_items.size() < 650) begin
      if ($urandom_range(0, 29) == 0) drain_next = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          for (k = 1; k <= 4; k++)
            if ($urandom_range(0, 2) == 0)
              queue_item(OP_ADDR_WRITE, 3'(k), 8'($urandom_range(0, 255)),
                         1'($urandom), 1'($urandom));
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5);
          queue_item(OP_CTRL_WRITE, 3'($urandom_range(0, 7)), 8'h80 | 8'(n),
                     1'($urandom), 1'($urandom));
          events = (n + 2 < 24) ? n + 2 : 24;
          for (k = 0; k < events; k++) begin
            case ($urandom_range(0, 9))
              0: queue_item(OP_REG_READ, 3'($urandom_range(1, 5)), 8'($urandom),
                            1'($urandom), 1'($urandom));
              1: queue_item(OP_CTRL_WRITE, 3'($urandom_range(0, 7)),
                            8'h80 | 8'($urandom_range(0, 4)), 1'($urandom), 1'($urandom));
              default: queue_item(OP_LINE_EVENT, 3'($urandom_range(0, 7)), 8'($urandom),
                                  1'($urandom), 1'($urandom));
            endcase
          end
          if ($urandom_range(0, 3) == 0)
            queue_item(OP_CTRL_WRITE, 3'($urandom_range(0, 7)),
                       8'($urandom_range(0, 127)), 1'($urandom), 1'($urandom));
        end
        4, 5: begin
          for (k = 1; k <= 4; k++)
            if ($urandom_range(0, 1) == 0)
              queue_item(OP_ADDR_WRITE, 3'(k), 8'($urandom_range(0, 255)),
                         1'($urandom), 1'($urandom));
          n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
          queue_item(OP_CTRL_WRITE, 3'($urandom_range(0, 7)), 8'(n),
                     1'($urandom), 1'($urandom));
        end
        6, 7: begin
          events = $urandom_range(1, 5);
          for (k = 0; k < events; k++)
            queue_item(OP_REG_READ, 3'($urandom_range(1, 5)), 8'($urandom),
                       1'($urandom), 1'($urandom));
        end
        default: begin
          events = $urandom_range(1, 3);
          for (k = 0; k < events; k++)
            queue_item(opcode_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                       8'($urandom_range(0, 255)), 1'($urandom), 1'($urandom));
        end
      endcase
    end
    bus_items_total = bus_items.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (bus_items_taken != bus_items_total || copy_results_due.size() != 0)
      @(posedge clk);
    // Extra settle time to catch any stray result.
    for (settle = 0; settle < 8; settle++) @(posedge clk);

    if (error_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Hang guard, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
